// File: hdl/fba_pkg.sv
// Shared types, widths and codes for the flagged band average block.
package fba_pkg;

    localparam int MAX_CHANNELS = 4096;
    localparam int SAMPLE_BITS  = 16;

    // Field widths fixed by the register map.
    localparam int NUM_CH_W = 13;
    localparam int WIN_W    = 12;

    localparam int IDX_W = $clog2(MAX_CHANNELS);
    localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
    localparam int SUM_W = SAMPLE_BITS + IDX_W;
    localparam int REM_W = CNT_W + 1;
    localparam int CMP_W = ((IDX_W > NUM_CH_W) ? IDX_W : NUM_CH_W) + 1;

    localparam int STEP_W = $clog2(SUM_W);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [NUM_CH_W-1:0] NUM_CHANNELS_RESET = NUM_CH_W'(256);
    localparam logic [WIN_W-1:0]    WINDOW_START_RESET = WIN_W'(51);
    localparam logic [WIN_W-1:0]    WINDOW_END_RESET   = WIN_W'(204);

    typedef enum logic [1:0] {
        REG_NUM_CHANNELS = 2'd0,
        REG_WINDOW_START = 2'd1,
        REG_WINDOW_END   = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_re;
        logic signed [SAMPLE_BITS-1:0] sample_im;
        logic                          sample_flagged;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] mean_re;
        logic signed [SAMPLE_BITS-1:0] mean_im;
        logic [1:0]                    status;
    } out_item_t;

    typedef struct packed {
        logic [NUM_CH_W-1:0] num_channels;
        logic [WIN_W-1:0]    window_start;
        logic [WIN_W-1:0]    window_end;
    } cfg_t;

    // One finished baseline, handed from the accumulator to the divider.
    typedef struct packed {
        logic signed [SUM_W-1:0] sum_re;
        logic signed [SUM_W-1:0] sum_im;
        logic [CNT_W-1:0]        counted;
        logic                    range_err;
    } job_t;

endpackage

// File: hdl/fba_regs.sv
// APB configuration registers of the flagged band average block.
module fba_regs import fba_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    reg_index_t index;
    logic       wr_en;

    assign index  = reg_index_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.num_channels <= NUM_CHANNELS_RESET;
            cfg_reg.window_start <= WINDOW_START_RESET;
            cfg_reg.window_end   <= WINDOW_END_RESET;
        end else if (wr_en) begin
            unique case (index)
                REG_NUM_CHANNELS: cfg_reg.num_channels <= pwdata[NUM_CH_W-1:0];
                REG_WINDOW_START: cfg_reg.window_start <= pwdata[WIN_W-1:0];
                REG_WINDOW_END:   cfg_reg.window_end   <= pwdata[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (index)
            REG_NUM_CHANNELS: prdata = APB_DATA_W'(cfg_reg.num_channels);
            REG_WINDOW_START: prdata = APB_DATA_W'(cfg_reg.window_start);
            REG_WINDOW_END:   prdata = APB_DATA_W'(cfg_reg.window_end);
            default:          prdata = '0;
        endcase
    end

endmodule

// File: hdl/fba_front.sv
// Front end: takes channel items, accumulates the window and closes each baseline.
module fba_front import fba_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    input  cfg_t     cfg,
    input  logic     queue_full,
    output logic     push_valid,
    output job_t     push_job
);

    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic signed [SUM_W-1:0] sum_re_reg, sum_re_next;
    logic signed [SUM_W-1:0] sum_im_reg, sum_im_next;
    logic [CNT_W-1:0]        counted_reg, counted_next;

    logic [CMP_W-1:0]        eff_n;
    logic [CMP_W-1:0]        idx_c;
    logic                    in_window;
    logic                    is_last;
    logic                    accept;
    logic signed [SUM_W-1:0] add_re;
    logic signed [SUM_W-1:0] add_im;

    assign s_ready = !queue_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        // Channel count of zero acts as one; anything above the maximum is clamped.
        if (cfg.num_channels == '0) begin
            eff_n = CMP_W'(1);
        end else if (CMP_W'(cfg.num_channels) > CMP_W'(MAX_CHANNELS)) begin
            eff_n = CMP_W'(MAX_CHANNELS);
        end else begin
            eff_n = CMP_W'(cfg.num_channels);
        end

        idx_c     = CMP_W'(idx_reg);
        in_window = !s_data.sample_flagged
                    && (idx_c >= CMP_W'(cfg.window_start))
                    && (idx_c <= CMP_W'(cfg.window_end));
        is_last   = (idx_c + CMP_W'(1)) >= eff_n;

        add_re = in_window ? SUM_W'(s_data.sample_re) : '0;
        add_im = in_window ? SUM_W'(s_data.sample_im) : '0;

        sum_re_next  = sum_re_reg + add_re;
        sum_im_next  = sum_im_reg + add_im;
        counted_next = counted_reg + CNT_W'(in_window);
        idx_next     = idx_reg + IDX_W'(1);

        push_valid         = accept && is_last;
        push_job.sum_re    = sum_re_next;
        push_job.sum_im    = sum_im_next;
        push_job.counted   = counted_next;
        push_job.range_err = (CMP_W'(cfg.window_start) >= eff_n)
                             || (CMP_W'(cfg.window_end) >= eff_n);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            sum_re_reg  <= '0;
            sum_im_reg  <= '0;
            counted_reg <= '0;
        end else if (accept) begin
            if (is_last) begin
                idx_reg     <= '0;
                sum_re_reg  <= '0;
                sum_im_reg  <= '0;
                counted_reg <= '0;
            end else begin
                idx_reg     <= idx_next;
                sum_re_reg  <= sum_re_next;
                sum_im_reg  <= sum_im_next;
                counted_reg <= counted_next;
            end
        end
    end

endmodule

// File: hdl/fba_queue.sv
// Short queue of finished baselines between the accumulator and the divider.
module fba_queue import fba_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic empty,
    output job_t head
);

    job_t              entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full  = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = entries[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: hdl/fba_back.sv
// Back end: divides each baseline's sums by its count and holds the result item.
module fba_back import fba_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      job_valid,
    input  job_t      job,
    output logic      pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_HOLD = 3'b100
    } back_state_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [SUM_W-1:0] quo;
    } div_lane_t;

    back_state_t state_reg, state_next;
    logic [STEP_W-1:0] step_reg;
    logic              m_valid_reg;
    out_item_t         m_data_reg;

    logic [CNT_W-1:0]  div_reg;
    div_lane_t         lane_re_reg, lane_im_reg;
    div_lane_t         lane_re_step, lane_im_step;
    logic              neg_re_reg, neg_im_reg;
    status_t           status_reg, job_status;
    logic [SUM_W-1:0]  res_re, res_im;
    logic              out_load;

    // One restoring step: bring in the next dividend bit, subtract if it fits.
    function automatic div_lane_t div_step(input div_lane_t cur, input logic [CNT_W-1:0] d);
        logic [REM_W-1:0] shifted;
        div_lane_t        nxt;
        shifted = {cur.rem[REM_W-2:0], cur.quo[SUM_W-1]};
        if (shifted >= REM_W'(d)) begin
            nxt.rem = shifted - REM_W'(d);
            nxt.quo = {cur.quo[SUM_W-2:0], 1'b1};
        end else begin
            nxt.rem = shifted;
            nxt.quo = {cur.quo[SUM_W-2:0], 1'b0};
        end
        return nxt;
    endfunction

    assign lane_re_step = div_step(lane_re_reg, div_reg);
    assign lane_im_step = div_step(lane_im_reg, div_reg);

    always_comb begin
        priority if (job.range_err) begin
            job_status = STATUS_RANGE;
        end else if (job.counted == '0) begin
            job_status = STATUS_EMPTY;
        end else begin
            job_status = STATUS_OK;
        end
    end

    assign pop      = (state_reg == ST_IDLE) && job_valid;
    assign out_load = (state_reg == ST_HOLD) && (!m_valid_reg || m_ready);
    assign res_re   = neg_re_reg ? -lane_re_reg.quo : lane_re_reg.quo;
    assign res_im   = neg_im_reg ? -lane_im_reg.quo : lane_im_reg.quo;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (job_valid) begin
                    state_next = (job_status == STATUS_OK) ? ST_DIV : ST_HOLD;
                end
            end
            ST_DIV: begin
                if (step_reg == '0) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (pop) begin
                step_reg <= STEP_W'(SUM_W - 1);
            end else if (state_reg == ST_DIV) begin
                step_reg <= step_reg - STEP_W'(1);
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Dividend is loaded as a magnitude; the quotient takes the sign back at the end.
    always_ff @(posedge aclk) begin
        if (pop) begin
            status_reg <= job_status;
            div_reg    <= job.counted;
            lane_re_reg.rem <= '0;
            lane_im_reg.rem <= '0;
            if (job_status == STATUS_OK) begin
                neg_re_reg      <= job.sum_re[SUM_W-1];
                neg_im_reg      <= job.sum_im[SUM_W-1];
                lane_re_reg.quo <= job.sum_re[SUM_W-1] ? -job.sum_re : job.sum_re;
                lane_im_reg.quo <= job.sum_im[SUM_W-1] ? -job.sum_im : job.sum_im;
            end else begin
                neg_re_reg      <= 1'b0;
                neg_im_reg      <= 1'b0;
                lane_re_reg.quo <= '0;
                lane_im_reg.quo <= '0;
            end
        end else if (state_reg == ST_DIV) begin
            lane_re_reg <= lane_re_step;
            lane_im_reg <= lane_im_step;
        end
        if (out_load) begin
            m_data_reg.mean_re <= res_re[SAMPLE_BITS-1:0];
            m_data_reg.mean_im <= res_im[SAMPLE_BITS-1:0];
            m_data_reg.status  <= status_reg;
        end
    end

endmodule

// File: hdl/flagged_band_average.sv
// Top level of the flagged band average block.
//
// The s_ channel carries the spectral channels of one baseline in order, one
// item per channel. Unflagged samples whose channel index lies in the window
// [window_start, window_end] are summed and counted. After the last channel
// the m_ channel delivers one item: the truncated mean of the counted samples,
// or a status of nothing counted or of a window outside the channel count.
// Registers num_channels, window_start and window_end sit at byte addresses
// 0x0, 0x4 and 0x8 of the APB port; the user is to write them only while the
// block is idle, which the block itself does not enforce. Channel items are
// taken at one per cycle while the queue is not full. The last channel of a
// baseline hands its sums to a two-entry queue; the divider works one quotient
// bit per cycle, and a result without a mean skips the divider. The divider
// takes a new baseline only after the last result moves to the output, so
// short baselines are paced by the divider once the queue is full.
// While m_ready is low the result is held in the output register, the divider
// finishes the next baseline, and input continues until the queue is full.
// Reset clears the channel counter, the sums, the queue and the output, and
// loads the registers with 256, 51 and 204.
module flagged_band_average import fba_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t cfg;
    logic push_valid;
    job_t push_job;
    logic queue_full;
    logic queue_empty;
    logic pop;
    job_t head;

    fba_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fba_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .cfg        (cfg),
        .queue_full (queue_full),
        .push_valid (push_valid),
        .push_job   (push_job)
    );

    fba_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push_valid),
        .push_job (push_job),
        .full     (queue_full),
        .pop      (pop),
        .empty    (queue_empty),
        .head     (head)
    );

    fba_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (!queue_empty),
        .job       (head),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// File: hdl/fba_checker.sv
// Port-level checks of the flagged band average block, bound to its top level.
module fba_checker import fba_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data,
    input logic      pready
);

    // A result that is not taken stays in place.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed or dropped while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status != 2'd3)
        else $error("undefined status code on result item");

    // Without a valid mean, both parts read as zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != STATUS_OK) |->
            (m_data.mean_re == '0) && (m_data.mean_im == '0))
        else $error("nonzero mean on a result item without a valid mean");

    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result item offered right after reset");

    assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("configuration port inserted a wait state");

endmodule

bind flagged_band_average fba_checker u_fba_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data),
    .pready  (pready)
);
